FILE: hw/rtl/slzm_pkg.sv
// ----------------------------------------------------------------------------
// slzm_pkg: shared types and constants for the SHA-1 leading-zero miner
// Holds commands, register indexes, the sequencer state type and helpers.
// ----------------------------------------------------------------------------
package slzm_pkg;

    localparam int COUNTER_BITS = 32;
    localparam int NUM_DIGITS   = (COUNTER_BITS + 5) / 6;
    // The digit counter also holds NUM_DIGITS for the load cycle of the round unit.
    localparam int DIG_W        = $clog2(NUM_DIGITS + 1);

    typedef enum logic [1:0] {
        CMD_LOAD_BLOCK = 2'd0,
        CMD_LOAD_CHAIN = 2'd1,
        CMD_RUN        = 2'd2,
        CMD_NONE       = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_TAIL   = 2'd2;
    localparam logic [1:0] REG_MAXIT  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_ROUNDS,
        ST_FINISH,
        ST_JUDGE,
        ST_EMIT
    } state_t;

    // Handshake between sequencer and hash core.
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } core_ctl_t;

    // Base64 alphabet entry for a six-bit value.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        begin
            if (v < 6'd26)      r = 8'h41 + {2'b00, v};
            else if (v < 6'd52) r = 8'h61 + {2'b00, v} - 8'd26;
            else if (v < 6'd62) r = 8'h30 + {2'b00, v} - 8'd52;
            else if (v == 6'd62) r = 8'h2B;
            else                 r = 8'h2F;
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/sha1_leading_zero_miner_unit.sv
// ----------------------------------------------------------------------------
// sha1_leading_zero_miner_unit: SHA-1 leading-zero proof-of-work search
// Loads block and chaining words, then searches counters for leading zeros.
// ----------------------------------------------------------------------------
// Each load writes one word of the block or of the chaining value. Each
// iteration of a run writes the counter digits (the last digit state loads
// the round unit), runs the 80 rounds of the shared round unit, then passes
// one feed-forward and one compare state. A hit on the target, or the digit
// state seeing the iteration limit reached, leads to emitting 16 result words,
// held under output stalls. Rounds run on the single round unit in slzm_core.
// in_stall is high from the run until the last result is taken.
module sha1_leading_zero_miner_unit
    import slzm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [3:0]  word_index,
    input  logic [31:0] word_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  out_index,
    output logic [31:0] out_word,
    output logic [6:0]  best_bits,
    output logic [32:0] iterations,
    output logic        found,
    output logic        last
);

    logic [6:0]  target_reg, start_reg, tail_reg;
    logic [31:0] maxit_reg;
    logic [15:0][31:0] blk_reg, work_reg, snap_reg;
    logic [4:0][31:0]  chain_reg;
    state_t state_reg, state_next;
    logic [6:0]  round_reg;
    logic [DIG_W-1:0] dig_reg;
    logic [32:0] iter_reg;
    logic [6:0]  thr_reg, best_reg;
    logic        found_reg;
    logic [3:0]  emit_reg;
    logic [63:0] digest;
    logic [6:0]  lz;
    core_ctl_t   ctl;
    logic        in_acc, cnt_done;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cnt_done  = (iter_reg[31:0] == maxit_reg) || iter_reg[32];

    slzm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .round     (round_reg),
        .blk       (work_reg),
        .chain     (chain_reg),
        .digest_top(digest)
    );

    // Leading zero count of the top 64 digest bits.
    always_comb
    begin
        lz = 7'd64;
        for (int j = 0; j < 64; j++)
        begin
            if (digest[j])
            begin
                lz = 7'(63 - j);
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && cmd == CMD_RUN)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (cnt_done)
                begin
                    state_next = ST_EMIT;
                end
                else if (dig_reg == DIG_W'(NUM_DIGITS))
                begin
                    state_next = ST_ROUNDS;
                end
            end
            ST_ROUNDS:
            begin
                if (round_reg == 7'd79)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_JUDGE;
            ST_JUDGE:
            begin
                if (lz >= thr_reg && lz >= target_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall && emit_reg == 4'd15)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control toward the round unit; the load follows the last digit write.
    always_comb
    begin
        ctl.start  = (state_reg == ST_DIGITS) && !cnt_done
                     && (dig_reg == DIG_W'(NUM_DIGITS));
        ctl.step   = (state_reg == ST_ROUNDS);
        ctl.finish = (state_reg == ST_FINISH);
    end

    // Sequencer counters and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            target_reg <= 7'd0;
            start_reg  <= 7'd0;
            tail_reg   <= 7'd64;
            maxit_reg  <= 32'd0;
            round_reg  <= 7'd0;
            dig_reg    <= '0;
            iter_reg   <= 33'd0;
            thr_reg    <= 7'd0;
            best_reg   <= 7'd0;
            found_reg  <= 1'b0;
            emit_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_TARGET: target_reg <= cfg_data[6:0];
                    REG_START:  start_reg  <= cfg_data[6:0];
                    REG_TAIL:   tail_reg   <= cfg_data[6:0];
                    REG_MAXIT:  maxit_reg  <= cfg_data;
                    default:    ;
                endcase
            end
            if (in_acc && cmd == CMD_RUN)
            begin
                if (target_reg == 7'd0)
                    thr_reg <= 7'd0;
                else if (start_reg != 7'd0)
                    thr_reg <= (start_reg == 7'd127) ? 7'd127 : start_reg + 7'd1;
                else
                    thr_reg <= (target_reg < 7'd16) ? target_reg : 7'd16;
                best_reg  <= start_reg;
                found_reg <= 1'b0;
                iter_reg  <= 33'd0;
                dig_reg   <= '0;
                emit_reg  <= 4'd0;
            end
            if (state_reg == ST_DIGITS)
            begin
                if (cnt_done)
                    iter_reg <= iter_reg + 33'd1;
                dig_reg <= dig_reg + DIG_W'(1);
                round_reg <= 7'd0;
            end
            if (state_reg == ST_ROUNDS)
                round_reg <= round_reg + 7'd1;
            if (state_reg == ST_JUDGE)
            begin
                dig_reg <= '0;
                iter_reg <= iter_reg + 33'd1;
                if (lz >= thr_reg)
                begin
                    if (lz > best_reg)
                        best_reg <= lz;
                    thr_reg <= lz + 7'd1;
                    if (lz >= target_reg)
                        found_reg <= 1'b1;
                end
            end
            if (state_reg == ST_EMIT && !out_stall)
                emit_reg <= emit_reg + 4'd1;
        end
    end

    // Block, working copy, snapshot and chaining storage.
    always_ff @(posedge clk)
    begin
        logic [COUNTER_BITS-1:0] cv;
        logic [COUNTER_BITS-1:0] hi;
        logic [7:0] pos;
        cv  = COUNTER_BITS'(iter_reg);
        hi  = cv >> (6 * int'(dig_reg));
        pos = {1'b0, tail_reg} - 8'd1 - {{(8 - DIG_W){1'b0}}, dig_reg};
        if (in_acc && cmd == CMD_LOAD_BLOCK)
            blk_reg[word_index] <= word_value;
        if (in_acc && cmd == CMD_LOAD_CHAIN && word_index < 4'd5)
            chain_reg[word_index[2:0]] <= word_value;
        if (in_acc && cmd == CMD_RUN)
        begin
            work_reg <= blk_reg;
            snap_reg <= blk_reg;
        end
        if (state_reg == ST_DIGITS && !cnt_done && pos[7:6] == 2'b00
            && dig_reg < DIG_W'(NUM_DIGITS)
            && (dig_reg == '0 || (cv[5:0] == 6'd0 && hi != '0)))
            work_reg[pos[5:2]][8 * (3 - int'(pos[1:0])) +: 8] <= b64_char(hi[5:0]);
        if (state_reg == ST_JUDGE && lz >= thr_reg)
            snap_reg <= work_reg;
        if (state_reg == ST_EMIT && !out_stall && emit_reg == 4'd15)
            blk_reg <= snap_reg;
    end

    assign out_valid  = (state_reg == ST_EMIT);
    assign out_index  = emit_reg;
    assign out_word   = snap_reg[emit_reg];
    assign best_bits  = best_reg;
    assign iterations = iter_reg;
    assign found      = found_reg;
    assign last       = (emit_reg == 4'd15);

    // The run never reports more iterations than allowed plus one.
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (iterations <= {1'b0, maxit_reg} + 33'd1))
        else $error("iteration count beyond limit");
    // A found run never has a best below the target.
    a_found_best: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (best_bits >= target_reg))
        else $error("found without reaching target");
    // Inputs are held off during the round states of a run.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUNDS) |-> in_stall)
        else $error("input taken during run");

endmodule

FILE: hw/rtl/slzm_core.sv
// ----------------------------------------------------------------------------
// slzm_core: iterative SHA-1 compression round unit
// One round per cycle over a 16-word schedule window, then the feed-forward of the first two words.
// ----------------------------------------------------------------------------
module slzm_core
    import slzm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  core_ctl_t         ctl,
    input  logic [6:0]        round,
    input  logic [15:0][31:0] blk,
    input  logic [4:0][31:0]  chain,
    output logic [63:0]       digest_top
);

    logic [15:0][31:0] w_reg, w_next;
    logic [4:0][31:0]  h_reg, h_next;
    logic [31:0] wt, f, k, tmp, a, b, c, d, e;

    assign a = h_reg[0];
    assign b = h_reg[1];
    assign c = h_reg[2];
    assign d = h_reg[3];
    assign e = h_reg[4];

    // Round function and schedule expansion for the current round.
    always_comb
    begin
        logic [31:0] x;
        x = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wt = (round < 7'd16) ? w_reg[0] : {x[30:0], x[31]};
        if (round < 7'd20)
        begin
            f = d ^ (b & (c ^ d));
            k = 32'h5A827999;
        end
        else if (round < 7'd40)
        begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
        end
        else if (round < 7'd60)
        begin
            f = (b & (c | d)) | (c & d);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
        end
        tmp = {a[26:0], a[31:27]} + f + e + k + wt;
    end

    // Next state of window and working variables.
    always_comb
    begin
        w_next = w_reg;
        h_next = h_reg;
        if (ctl.start)
        begin
            w_next = blk;
            h_next = chain;
        end
        else if (ctl.step)
        begin
            w_next = {wt, w_reg[15:1]};
            h_next = {d, c, {b[1:0], b[31:2]}, a, tmp};
        end
        else if (ctl.finish)
        begin
            h_next[0] = a + chain[0];
            h_next[1] = b + chain[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
            h_reg <= '0;
        end
        else
        begin
            w_reg <= w_next;
            h_reg <= h_next;
        end
    end

    assign digest_top = {h_reg[0], h_reg[1]};

endmodule
